@@ rtl/core/hms_pkg.sv @@
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types and constants for the 3x3 heightmap mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package hms_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W     = $clog2(MAX_WIDTH);  // line buffer index
  localparam int WID_W     = COL_W + 1;          // holds MAX_WIDTH itself
  localparam int ROW_W     = 13;                 // holds MAX_HEIGHT + 1
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 12;                 // 9 * 255
  localparam int CNT_W     = 4;                  // up to 9 cells
  localparam int REM_W     = 5;                  // remainder below 2 * 9
  localparam int OUT_W     = 16;
  localparam int DIV_STEPS = 16;
  localparam int STEP_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd257;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd257;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] height_sample;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] smoothed_height;
    logic             last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic mem_rd;    // capture sample, read line buffers
    logic update;    // shift window, write buffers, load divider, advance
    logic div_step;  // one quotient bit
    logic out_load;  // move quotient into output register
  } dp_cmd_t;

  typedef struct packed {
    logic frame_full;  // all samples of the frame have arrived
    logic due;         // current item produces a result
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/heightmap_3x3_mean_smoothing.sv @@
// ----------------------------------------------------------------------------
// heightmap_3x3_mean_smoothing
// 3x3 box mean over a raster heightmap stream, 8.8 fixed-point results.
// ----------------------------------------------------------------------------
// Sequence: a request that yields a result goes through line buffer read,
//   window update, 16 divider steps and output load, waiting while the result
//   register is still full; one with no result stops after the update.
// Throughput: one request at a time, set by the bit-serial divider.
// Reset: synchronous; positions and window clear, registers return to 257;
//   line buffers are not cleared and need no clearing pass.
`default_nettype none

module heightmap_3x3_mean_smoothing (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  hms_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output hms_pkg::out_item_t             out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [hms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [hms_pkg::CFG_W-1:0]      cfg_data
);
  import hms_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // registers change only while idle with no request offered
  assign cfg_ready = in_ready && !in_valid;

  hms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  hms_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  ap_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  ap_load_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> in_ready && out_valid)
    else $error("result load did not return to idle with output valid");

  ap_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.update && !status.due |=> in_ready && !cmd.div_step)
    else $error("request without result entered the divider");

  ap_early_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == ACT_DRAIN && !status.frame_full
    |=> in_ready && !cmd.update)
    else $error("early drain request touched the datapath");

endmodule

`default_nettype wire

@@ rtl/core/hms_ctrl.sv @@
// ----------------------------------------------------------------------------
// hms_ctrl
// Sequencer: accepts a request, steps the datapath, owns output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_action,
  output logic                in_ready,
  input  wire                 out_ready,
  output logic                out_valid,
  input  hms_pkg::dp_status_t status,
  output hms_pkg::dp_cmd_t    cmd
);
  import hms_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_ready      = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        // a drain before the frame is complete is taken and dropped
        if (in_valid && !(in_action == ACT_DRAIN && !status.frame_full)) begin
          cmd.mem_rd = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update    = 1'b1;
        step_cnt_next = '0;
        state_next    = status.due ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

`default_nettype wire

@@ rtl/core/hms_datapath.sv @@
// ----------------------------------------------------------------------------
// hms_datapath
// Line buffers, window, position counters, neighborhood sum and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [hms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [hms_pkg::CFG_W-1:0]           cfg_data,
  input  hms_pkg::in_item_t                   in_data,
  input  hms_pkg::dp_cmd_t                    cmd,
  output hms_pkg::dp_status_t                 status,
  output hms_pkg::out_item_t                  out_data
);
  import hms_pkg::*;

  logic [CFG_W-1:0] width_reg, height_reg;
  logic [WID_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  logic [COL_W-1:0] ac, ec;
  logic [ROW_W-1:0] ar, er;

  // window left and center columns; the right column comes from col_in
  logic [PIX_W-1:0] win [3][2];

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_q, newer_q, v_q;
  logic [PIX_W-1:0] col_in [3];

  logic             e_top, e_bot, e_left, e_right, col_more, last;
  logic [9:0]       rs [3];
  logic [SUM_W-1:0] sum;
  logic [1:0]       rows, cols;
  logic [CNT_W-1:0] cnt;
  logic [WID_W-1:0] ac_inc, ec_inc;

  logic [REM_W-1:0] rem;
  logic [OUT_W-1:0] quo;
  logic [REM_W-1:0] dvs;
  logic [REM_W:0]   trial;
  logic             last_q;

  always_comb begin
    if (width_reg == '0) eff_w = WID_W'(1);
    else if (32'(width_reg) > MAX_WIDTH) eff_w = WID_W'(MAX_WIDTH);
    else eff_w = WID_W'(width_reg);
    if (height_reg == '0) eff_h = ROW_W'(1);
    else if (32'(height_reg) > MAX_HEIGHT) eff_h = ROW_W'(MAX_HEIGHT);
    else eff_h = ROW_W'(height_reg);
  end

  assign status.frame_full = (ar >= eff_h);
  assign status.due        = (ar >= ROW_W'(2)) || (ar == ROW_W'(1) && ac != '0);

  assign col_in[0] = older_q;
  assign col_in[1] = newer_q;
  assign col_in[2] = v_q;

  assign ac_inc   = WID_W'(ac) + 1'b1;
  assign ec_inc   = WID_W'(ec) + 1'b1;
  assign col_more = (ec_inc < eff_w);
  assign e_top    = (er != '0);
  assign e_bot    = ({1'b0, er} + 1'b1) < {1'b0, eff_h};
  assign e_left   = (ec != '0);
  // first column of a row closes the previous row: no right neighbor
  assign e_right  = (ac != '0) && col_more;
  assign last     = !e_bot && !col_more;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rs[r] = (e_left ? 10'(win[r][0]) : 10'd0) + 10'(win[r][1])
            + (e_right ? 10'(col_in[r]) : 10'd0);
    end
    sum  = (e_top ? SUM_W'(rs[0]) : '0) + SUM_W'(rs[1]) + (e_bot ? SUM_W'(rs[2]) : '0);
    rows = 2'd1 + 2'(e_top) + 2'(e_bot);
    cols = 2'd1 + 2'(e_left) + 2'(e_right);
    cnt  = CNT_W'(rows) * CNT_W'(cols);
  end

  // control state: config, positions, window
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      ac <= '0;
      ar <= '0;
      ec <= '0;
      er <= '0;
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= '0;
        win[r][1] <= '0;
      end
    end else begin
      if (cmd.update) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= col_in[r];
        end
        if (status.due && last) begin
          ac <= '0;
          ar <= '0;
          ec <= '0;
          er <= '0;
        end else begin
          if (ac_inc >= eff_w) begin
            ac <= '0;
            ar <= ar + 1'b1;
          end else begin
            ac <= ac_inc[COL_W-1:0];
          end
          if (status.due) begin
            if (ec_inc >= eff_w) begin
              ec <= '0;
              er <= er + 1'b1;
            end else begin
              ec <= ec_inc[COL_W-1:0];
            end
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg <= cfg_data;
            ac <= '0;
            ar <= '0;
            ec <= '0;
            er <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg <= cfg_data;
            ac <= '0;
            ar <= '0;
            ec <= '0;
            er <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // line buffers: read on accept, write back on update
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      older_q <= older_mem[ac];
      newer_q <= newer_mem[ac];
      v_q     <= status.frame_full ? '0 : in_data.height_sample;
    end
    if (cmd.update) begin
      older_mem[ac] <= newer_q;
      newer_mem[ac] <= v_q;
    end
  end

  // restoring divider: (sum*512 + cnt) / (2*cnt); quotient fits 16 bits,
  // so the top five numerator bits start as the remainder
  assign trial = {rem, quo[OUT_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rem    <= sum[SUM_W-1 -: REM_W];
      quo    <= {sum[SUM_W-REM_W-1:0], 5'd0, cnt};
      dvs    <= {cnt, 1'b0};
      last_q <= last;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= REM_W'(trial - {1'b0, dvs});
        quo <= {quo[OUT_W-2:0], 1'b1};
      end else begin
        rem <= trial[REM_W-1:0];
        quo <= {quo[OUT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_data.smoothed_height <= quo;
      out_data.last_of_frame   <= last_q;
    end
  end

endmodule

`default_nettype wire
